// File: hdl/clim_pkg.sv
// Shared types, codes and sizes for the processor load interval matcher.
package clim_pkg;

	// Default sizes
	localparam int NUM_CPUS_DEF      = 8;
	localparam int NUM_INTERVALS_DEF = 8;

	// Request codes
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_TABLE  = 2'd1;
	localparam logic [1:0] REQ_EVAL   = 2'd2;

	// Target and slot codes
	localparam logic [3:0] CODE_AGG = 4'd8;
	localparam logic [3:0] CODE_ANY = 4'd9;
	localparam logic [3:0] CODE_ALL = 4'd10;

	// Register indexes on the configuration port
	localparam logic REG_INTERVAL_COUNT = 1'b0;
	localparam logic REG_COUNTER_FORMAT = 1'b1;

	// Nice scale used when zero is written (3.0 in Q8.8)
	localparam logic [15:0] DEFAULT_SCALE = 16'd768;
	// Saturated load percentage
	localparam logic [6:0]  PCT_FULL      = 7'd100;
	// Quotient bits of the nice divide (32-bit count shifted by 8)
	localparam int          NICE_QW       = 40;

	// One processor slot of counters
	typedef struct packed {
		logic [31:0] cur_user;
		logic [31:0] cur_nice;
		logic [31:0] cur_system;
		logic [31:0] cur_total;
		logic [31:0] cur_delta_total;
		logic [31:0] old_user;
		logic [31:0] old_nice;
		logic [31:0] old_system;
	} slot_rec_t;

	// One interval table entry
	typedef struct packed {
		logic [3:0]  target;
		logic [7:0]  low;
		logic [7:0]  high;
		logic [15:0] scale;
	} tbl_rec_t;

endpackage

// File: hdl/clim_req_if.sv
// Request channel: valid/ready handshake with the request payload.
interface clim_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [3:0]  slot;
	logic [31:0] user_ticks;
	logic [31:0] nice_ticks;
	logic [31:0] system_ticks;
	logic [31:0] idle_ticks;
	logic [31:0] irq_ticks;
	logic [31:0] softirq_ticks;
	logic [3:0]  interval_target;
	logic [7:0]  interval_low;
	logic [7:0]  interval_high;
	logic [15:0] nice_scale_q8;

	modport source (
		output valid, req_type, slot, user_ticks, nice_ticks, system_ticks, idle_ticks,
		output irq_ticks, softirq_ticks, interval_target, interval_low, interval_high,
		output nice_scale_q8,
		input  ready
	);
	modport sink (
		input  valid, req_type, slot, user_ticks, nice_ticks, system_ticks, idle_ticks,
		input  irq_ticks, softirq_ticks, interval_target, interval_low, interval_high,
		input  nice_scale_q8,
		output ready
	);
endinterface

// File: hdl/clim_rsp_if.sv
// Result channel: valid/ready handshake with the result payload.
interface clim_rsp_if;
	logic       valid;
	logic       ready;
	logic       matched;
	logic [1:0] done_kind;

	modport source (output valid, matched, done_kind, input ready);
	modport sink (input valid, matched, done_kind, output ready);
endinterface

// File: hdl/clim_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module clim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/cpu_load_interval_matcher.sv
// Top level of the processor load interval matcher: control, datapath and memories.
//
//   channel | direction | transfer when
//   req     | in        | req.valid & req.ready
//   rsp     | out       | rsp.valid & rsp.ready
//   apb     | in        | psel & penable & pwrite (pready always high)
//
// Evaluate: per processor looked at, two 40-step serial divides of the nice counts and,
// unless the load is settled early, a 7-step percentage divide.
// Reset clears the counter slots through per-slot valid bits, no clearing pass.
// A new request is taken while a finished result still waits in the output register.
module cpu_load_interval_matcher
	import clim_pkg::*;
#(
	parameter int NUM_CPUS      = NUM_CPUS_DEF,
	parameter int NUM_INTERVALS = NUM_INTERVALS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	clim_req_if.sink    req,
	clim_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOTS = NUM_CPUS + 1;
	localparam int CW    = $clog2(SLOTS);
	localparam int TAW   = (NUM_INTERVALS > 1) ? $clog2(NUM_INTERVALS) : 1;
	localparam int KW    = $clog2(NUM_INTERVALS + 1);
	localparam logic [5:0] DIV_LAST = 6'(NICE_QW - 1);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_SMP_RD = 15'b000000000000010,
		ST_SMP_WR = 15'b000000000000100,
		ST_NEXT   = 15'b000000000001000,
		ST_TBL    = 15'b000000000010000,
		ST_SRD    = 15'b000000000100000,
		ST_SLAT   = 15'b000000001000000,
		ST_DCUR   = 15'b000000010000000,
		ST_DOLD   = 15'b000000100000000,
		ST_PREP   = 15'b000001000000000,
		ST_PCMP   = 15'b000010000000000,
		ST_PMUL   = 15'b000100000000000,
		ST_PDIV   = 15'b001000000000000,
		ST_JUDGE  = 15'b010000000000000,
		ST_DONE   = 15'b100000000000000
	} state_t;

	state_t           state_q;
	logic [3:0]       icount_q;
	logic             cfmt_q;
	logic [SLOTS-1:0] vld_q;
	logic             out_vld_q;
	logic             out_match_q;
	logic [1:0]       out_kind_q;

	logic [1:0]       req_q;
	logic             match_q;
	logic [CW-1:0]    c_q;
	logic [KW-1:0]    k_q;
	logic [31:0]      smp_user_q, smp_nice_q, smp_sys_q, smp_tot_q;
	logic [3:0]       tgt_q;
	logic [7:0]       lo_q, hi_q;
	logic [15:0]      scale_q;
	slot_rec_t        ent_q;
	logic [15:0]      drem_q;
	logic [NICE_QW-1:0] dnum_q, qcur_q, qold_q;
	logic [5:0]       dcnt_q;
	logic [NICE_QW:0] now_q, bef_q;
	logic [31:0]      dlt_q;
	logic [38:0]      prem_q;
	logic [37:0]      pdiv_q;
	logic [2:0]       pcnt_q;
	logic [6:0]       pct_q;

	logic             in_fire, out_free;
	logic             smp_ok;
	logic [CW-1:0]    smp_idx;
	logic             tbl_we;
	tbl_rec_t         tbl_wdata, tbl_rdata;
	logic [$bits(slot_rec_t)-1:0] slot_rdata;
	slot_rec_t        slot_ent, smp_new;
	logic             eval_end, tgt_ok;
	logic [16:0]      dtrial;
	logic             dge;
	logic [15:0]      drem_nx;
	logic [NICE_QW-1:0] dnum_nx;
	logic             pge;
	logic [38:0]      prem_nx;
	logic [NICE_QW:0] dsub;
	logic             pct_early;
	logic             pin, c_last, judge_hit, judge_cont;
	logic             cfg_we;

	// Handshakes
	assign req.ready     = (state_q == ST_IDLE);
	assign in_fire       = req.valid & req.ready;
	assign out_free      = !out_vld_q || rsp.ready;
	assign rsp.valid     = out_vld_q;
	assign rsp.matched   = out_match_q;
	assign rsp.done_kind = out_kind_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;
	always_comb begin
		unique case (paddr[2])
			REG_INTERVAL_COUNT: prdata = {28'd0, icount_q};
			REG_COUNTER_FORMAT: prdata = {31'd0, cfmt_q};
			default:            prdata = '0;
		endcase
	end

	// Sample slot decode
	always_comb begin
		smp_ok  = 1'b0;
		smp_idx = '0;
		if (req.slot == CODE_AGG) begin
			smp_ok  = 1'b1;
			smp_idx = CW'(NUM_CPUS);
		end else if (req.slot < CODE_AGG && 32'(req.slot) < NUM_CPUS) begin
			smp_ok  = 1'b1;
			smp_idx = CW'(req.slot);
		end
	end

	// Interval table write straight from the accepted request
	assign tbl_we = in_fire && req.req_type == REQ_TABLE && 32'(req.slot) < NUM_INTERVALS;
	always_comb begin
		tbl_wdata.target = req.interval_target;
		tbl_wdata.low    = req.interval_low;
		tbl_wdata.high   = req.interval_high;
		tbl_wdata.scale  = (req.nice_scale_q8 == 16'd0) ? DEFAULT_SCALE : req.nice_scale_q8;
	end

	clim_ram #(.WIDTH($bits(tbl_rec_t)), .DEPTH(NUM_INTERVALS)) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (TAW'(req.slot)),
		.wdata (tbl_wdata),
		.re    (state_q == ST_NEXT),
		.raddr (TAW'(k_q)),
		.rdata (tbl_rdata)
	);

	// Slot read masked by its valid bit; new slot contents for a sample
	assign slot_ent = vld_q[c_q] ? slot_rec_t'(slot_rdata) : '0;
	always_comb begin
		smp_new.old_user        = slot_ent.cur_user;
		smp_new.old_nice        = slot_ent.cur_nice;
		smp_new.old_system      = slot_ent.cur_system;
		smp_new.cur_delta_total = smp_tot_q - slot_ent.cur_total;
		smp_new.cur_total       = smp_tot_q;
		smp_new.cur_user        = smp_user_q;
		smp_new.cur_nice        = smp_nice_q;
		smp_new.cur_system      = smp_sys_q;
	end

	clim_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (state_q == ST_SMP_WR),
		.waddr (c_q),
		.wdata (smp_new),
		.re    (state_q == ST_SMP_RD || state_q == ST_SRD),
		.raddr (c_q),
		.rdata (slot_rdata)
	);

	// Interval walk control
	assign eval_end = 32'(k_q) >= 32'(icount_q) || 32'(k_q) >= NUM_INTERVALS;
	assign tgt_ok   = tbl_rdata.target == CODE_ANY || tbl_rdata.target == CODE_ALL ||
	                  tbl_rdata.target == CODE_AGG ||
	                  (tbl_rdata.target < CODE_AGG && 32'(tbl_rdata.target) < NUM_CPUS);

	// Nice divide step: restoring, one quotient bit per cycle
	assign dtrial  = {drem_q, dnum_q[NICE_QW-1]};
	assign dge     = dtrial >= {1'b0, scale_q};
	assign drem_nx = dge ? 16'(dtrial - {1'b0, scale_q}) : dtrial[15:0];
	assign dnum_nx = {dnum_q[NICE_QW-2:0], dge};

	// Percentage divide step: quotient is at most 100, so seven bits
	assign pge     = prem_q >= {1'b0, pdiv_q};
	assign prem_nx = pge ? prem_q - {1'b0, pdiv_q} : prem_q;

	// Load delta checks
	assign dsub      = now_q - bef_q;
	assign pct_early = ent_q.cur_delta_total == 32'd0 || now_q < bef_q ||
	                   dsub > (NICE_QW+1)'(ent_q.cur_delta_total);

	// Interval judgment
	assign pin        = {1'b0, pct_q} >= lo_q && {1'b0, pct_q} <= hi_q;
	assign c_last     = 32'(c_q) == NUM_CPUS - 1;
	assign judge_hit  = (tgt_q == CODE_ALL) ? (pin && c_last) : pin;
	assign judge_cont = (tgt_q == CODE_ANY) ? (!pin && !c_last) :
	                    (tgt_q == CODE_ALL) ? (pin && !c_last) : 1'b0;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			icount_q  <= 4'd0;
			cfmt_q    <= 1'b1;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (paddr[2])
					REG_INTERVAL_COUNT: icount_q <= pwdata[3:0];
					REG_COUNTER_FORMAT: cfmt_q   <= pwdata[0];
					default: ;
				endcase
			end

			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (req.req_type)
							REQ_SAMPLE: state_q <= smp_ok ? ST_SMP_RD : ST_DONE;
							REQ_EVAL:   state_q <= ST_NEXT;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_SMP_RD: state_q <= ST_SMP_WR;
				ST_SMP_WR: begin
					vld_q[c_q] <= 1'b1;
					state_q    <= ST_DONE;
				end
				ST_NEXT:  state_q <= eval_end ? ST_DONE : ST_TBL;
				ST_TBL:   state_q <= tgt_ok ? ST_SRD : ST_NEXT;
				ST_SRD:   state_q <= ST_SLAT;
				ST_SLAT:  state_q <= ST_DCUR;
				ST_DCUR:  if (dcnt_q == DIV_LAST) state_q <= ST_DOLD;
				ST_DOLD:  if (dcnt_q == DIV_LAST) state_q <= ST_PREP;
				ST_PREP:  state_q <= ST_PCMP;
				ST_PCMP:  state_q <= pct_early ? ST_JUDGE : ST_PMUL;
				ST_PMUL:  state_q <= ST_PDIV;
				ST_PDIV:  if (pcnt_q == 3'd0) state_q <= ST_JUDGE;
				ST_JUDGE: begin
					if (judge_hit) begin
						state_q <= ST_DONE;
					end else if (judge_cont) begin
						state_q <= ST_SRD;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_DONE:  if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					req_q      <= req.req_type;
					match_q    <= 1'b0;
					k_q        <= '0;
					c_q        <= smp_idx;
					smp_user_q <= req.user_ticks;
					smp_nice_q <= req.nice_ticks;
					smp_sys_q  <= cfmt_q ?
					              req.system_ticks + req.irq_ticks + req.softirq_ticks :
					              req.system_ticks;
					smp_tot_q  <= req.user_ticks + req.nice_ticks + req.system_ticks +
					              req.idle_ticks;
				end
			end
			ST_TBL: begin
				tgt_q   <= tbl_rdata.target;
				lo_q    <= tbl_rdata.low;
				hi_q    <= tbl_rdata.high;
				scale_q <= tbl_rdata.scale;
				if (tbl_rdata.target == CODE_ANY || tbl_rdata.target == CODE_ALL) begin
					c_q <= '0;
				end else if (tbl_rdata.target == CODE_AGG) begin
					c_q <= CW'(NUM_CPUS);
				end else begin
					c_q <= CW'(tbl_rdata.target);
				end
				if (!tgt_ok) begin
					k_q <= k_q + 1'b1;
				end
			end
			ST_SLAT: begin
				ent_q  <= slot_ent;
				drem_q <= '0;
				dnum_q <= {slot_ent.cur_nice, 8'd0};
				dcnt_q <= '0;
			end
			ST_DCUR: begin
				drem_q <= drem_nx;
				dnum_q <= dnum_nx;
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == DIV_LAST) begin
					qcur_q <= dnum_nx;
					drem_q <= '0;
					dnum_q <= {ent_q.old_nice, 8'd0};
					dcnt_q <= '0;
				end
			end
			ST_DOLD: begin
				drem_q <= drem_nx;
				dnum_q <= dnum_nx;
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == DIV_LAST) begin
					qold_q <= dnum_nx;
				end
			end
			ST_PREP: begin
				now_q <= (NICE_QW+1)'(ent_q.cur_user) + (NICE_QW+1)'(qcur_q) +
				         (NICE_QW+1)'(ent_q.cur_system);
				bef_q <= (NICE_QW+1)'(ent_q.old_user) + (NICE_QW+1)'(qold_q) +
				         (NICE_QW+1)'(ent_q.old_system);
			end
			ST_PCMP: begin
				dlt_q <= dsub[31:0];
				if (pct_early) begin
					pct_q <= PCT_FULL;
				end
			end
			ST_PMUL: begin
				prem_q <= {7'd0, dlt_q} * 39'd100;
				pdiv_q <= {ent_q.cur_delta_total, 6'd0};
				pcnt_q <= 3'd6;
				pct_q  <= '0;
			end
			ST_PDIV: begin
				prem_q <= prem_nx;
				pdiv_q <= pdiv_q >> 1;
				pct_q  <= {pct_q[5:0], pge};
				pcnt_q <= pcnt_q - 1'b1;
			end
			ST_JUDGE: begin
				if (judge_hit) begin
					match_q <= 1'b1;
				end else if (judge_cont) begin
					c_q <= c_q + 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_match_q <= match_q;
					out_kind_q  <= req_q;
				end
			end
			default: ;
		endcase
	end

	// The percentage handed to the judgment never exceeds full load
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_JUDGE |-> pct_q <= PCT_FULL)
		else $error("load percentage above 100");

	// Only the sample write step touches the counter slots
	a_slot_wr: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q != $past(vld_q) |-> $past(state_q) == ST_SMP_WR)
		else $error("slot marked valid outside a sample");

	// A finished request with a free output register shows a result next cycle
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_vld_q) |=> (out_vld_q && state_q == ST_IDLE))
		else $error("result not presented after completion");

	// Only an evaluate can report a match
	a_match_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_match_q) |-> out_kind_q == REQ_EVAL)
		else $error("match reported for a non-evaluate request");

endmodule
